/* hdl/ssd_pkg.sv */
package ssd_pkg;

   localparam int CW     = 24;             // coordinate width
   localparam int NC     = 12;             // coordinates per input word
   localparam int DW     = CW + 1;         // difference vector component width
   localparam int PB     = 16;             // fraction bits of s and t
   localparam int QW     = PB + 1;         // width of s and t
   localparam int PRW    = 2 * DW;         // product of two components
   localparam int DOTW   = PRW + 1;        // signed dot product
   localparam int MW     = DOTW;           // wide multiplier operand
   localparam int LO_W   = 25;             // low split of a multiplier operand
   localparam int HI_W   = MW - LO_W;      // high (signed) split
   localparam int PW     = 2 * MW;         // wide multiplier product
   localparam int NUM_W  = PW;             // divider numerator
   localparam int DEN_W  = 2 * (DOTW - 1); // divider denominator
   localparam int THR_W  = 21;
   localparam int CMPW   = DW + PB + 2;    // component of the separation vector
   localparam int SQW    = 2 * CMPW;
   localparam int SUM_W  = SQW + 2;
   localparam int DIST_W = 52;
   localparam int IN_W   = NC * CW;
   localparam int OUT_W  = ((DIST_W + 2 * QW + 7) / 8) * 8;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);
   localparam logic [QW-1:0]    ONE_Q     = QW'(1) << PB;
   localparam logic [SUM_W-1:0] ROUND     = SUM_W'(1) << (2 * PB - 1);

   // Pipeline timing, in register stages after the input word is taken.
   localparam int MUL_LAT  = 2;
   localparam int DIV_LAT  = PB + 1;
   localparam int DIST_LAT = 7;
   localparam int ST_DOT   = 3;
   localparam int ST_PRE   = ST_DOT + 1;
   localparam int ST_WM    = ST_DOT + MUL_LAT;
   localparam int ST_SN    = ST_WM + 1;
   localparam int ST_ALT   = ST_PRE + DIV_LAT;
   localparam int ST_S0    = ST_SN + DIV_LAT;
   localparam int ST_BS    = ST_S0 + MUL_LAT;
   localparam int ST_TN    = ST_BS + 1;
   localparam int ST_T     = ST_TN + DIV_LAT;
   localparam int ST_OUT   = ST_T + DIST_LAT;

   typedef logic signed [DW-1:0]   diff_type;
   typedef logic signed [DOTW-1:0] dot_type;

   typedef struct packed {
      diff_type [2:0] d1;
      diff_type [2:0] d2;
      diff_type [2:0] r;
   } geo_type;

   typedef struct packed {
      dot_type        b;
      dot_type        f;
      dot_type        e;
      logic           pa;
      logic           pe;
      logic [QW-1:0]  q_neg;
      logic [QW-1:0]  q_bc;
      logic [QW-1:0]  s0;
      geo_type        geo;
   } side_type;

   typedef struct packed {
      logic          neg;
      logic          gt;
      logic [QW-1:0] q;
   } div_res_type;

endpackage

/* hdl/ssd_mul.sv */
module ssd_mul (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [ssd_pkg::MW-1:0]   a_i,
   input  logic signed [ssd_pkg::MW-1:0]   b_i,
   output logic signed [ssd_pkg::PW-1:0]   p_o
);
   import ssd_pkg::*;

   logic signed [2*HI_W-1:0] hh_in, hl_in, lh_in, hh_ff, hl_ff, lh_ff;
   logic [2*LO_W-1:0]        ll_in, ll_ff;
   logic signed [PW-1:0]     p_in, p_ff;

   // Each operand splits into a signed high part and an unsigned low part.
   always_comb begin
      hh_in = $signed(a_i[MW-1:LO_W]) * $signed(b_i[MW-1:LO_W]);
      hl_in = $signed(a_i[MW-1:LO_W]) * $signed({1'b0, b_i[LO_W-1:0]});
      lh_in = $signed({1'b0, a_i[LO_W-1:0]}) * $signed(b_i[MW-1:LO_W]);
      ll_in = a_i[LO_W-1:0] * b_i[LO_W-1:0];
      p_in  = (PW'(hh_ff) <<< (2 * LO_W)) + ((PW'(hl_ff) + PW'(lh_ff)) <<< LO_W)
            + PW'($signed({1'b0, ll_ff}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
         p_ff  <= p_in;
      end
   end

   assign p_o = p_ff;

endmodule

/* hdl/ssd_div.sv */
module ssd_div (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [ssd_pkg::NUM_W-1:0]  num_i,
   input  logic [ssd_pkg::DEN_W-1:0]         den_i,
   output ssd_pkg::div_res_type              res_o
);
   import ssd_pkg::*;

   logic signed [NUM_W-1:0] den_ext;
   logic                    nonpos, big;
   logic [DEN_W-1:0]        rem_ff [0:PB];
   logic [DEN_W-1:0]        den_ff [0:PB];
   logic [PB-1:0]           q_ff   [0:PB];
   logic                    fix_ff [0:PB];
   logic                    fone_ff[0:PB];
   logic                    neg_ff [0:PB];
   logic                    gt_ff  [0:PB];
   logic [DEN_W:0]          rem2   [1:PB];
   logic                    ge     [1:PB];
   logic [DEN_W-1:0]        rem_in [1:PB];
   logic [PB-1:0]           q_in   [1:PB];

   always_comb begin
      den_ext = $signed(NUM_W'(den_i));
      nonpos  = num_i[NUM_W-1] || (num_i == '0);
      big     = num_i >= den_ext;
      for (int i = 1; i <= PB; i++) begin
         rem2[i]   = {rem_ff[i-1], 1'b0};
         ge[i]     = rem2[i] >= {1'b0, den_ff[i-1]};
         rem_in[i] = ge[i] ? DEN_W'(rem2[i] - {1'b0, den_ff[i-1]}) : rem2[i][DEN_W-1:0];
         q_in[i]   = {q_ff[i-1][PB-2:0], ge[i]};
      end
   end

   // Stage zero settles the clamped cases; the others each find one quotient bit.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num_i[DEN_W-1:0];
         den_ff[0]  <= den_i;
         q_ff[0]    <= '0;
         fix_ff[0]  <= nonpos || big;
         fone_ff[0] <= !nonpos && big;
         neg_ff[0]  <= num_i[NUM_W-1];
         gt_ff[0]   <= num_i > den_ext;
         for (int i = 1; i <= PB; i++) begin
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= den_ff[i-1];
            q_ff[i]    <= q_in[i];
            fix_ff[i]  <= fix_ff[i-1];
            fone_ff[i] <= fone_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
            gt_ff[i]   <= gt_ff[i-1];
         end
      end
   end

   always_comb begin
      res_o.neg = neg_ff[PB];
      res_o.gt  = gt_ff[PB];
      if (fix_ff[PB]) begin
         res_o.q = fone_ff[PB] ? ONE_Q : '0;
      end else begin
         res_o.q = {1'b0, q_ff[PB]};
      end
   end

endmodule

/* hdl/ssd_dot.sv */
module ssd_dot (
   input  logic                         clock,
   input  logic                         en,
   input  logic [ssd_pkg::IN_W-1:0]     coord_i,
   output ssd_pkg::dot_type             a_o,
   output ssd_pkg::dot_type             e_o,
   output ssd_pkg::dot_type             b_o,
   output ssd_pkg::dot_type             c_o,
   output ssd_pkg::dot_type             f_o,
   output ssd_pkg::geo_type             geo_o
);
   import ssd_pkg::*;

   function automatic diff_type csub(logic [CW-1:0] x, logic [CW-1:0] y);
      return DW'($signed(x)) - DW'($signed(y));
   endfunction

   geo_type              geo1_in, geo1_ff, geo2_ff, geo3_ff;
   logic signed [PRW-1:0] pa_in [0:2], pe_in [0:2], pb_in [0:2], pc_in [0:2], pf_in [0:2];
   logic signed [PRW-1:0] pa_ff [0:2], pe_ff [0:2], pb_ff [0:2], pc_ff [0:2], pf_ff [0:2];
   dot_type              a_in, e_in, b_in, c_in, f_in;
   dot_type              a_ff, e_ff, b_ff, c_ff, f_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         geo1_in.d1[k] = csub(coord_i[(3+k)*CW +: CW], coord_i[k*CW +: CW]);
         geo1_in.d2[k] = csub(coord_i[(9+k)*CW +: CW], coord_i[(6+k)*CW +: CW]);
         geo1_in.r[k]  = csub(coord_i[k*CW +: CW], coord_i[(6+k)*CW +: CW]);
         pa_in[k] = $signed(geo1_ff.d1[k]) * $signed(geo1_ff.d1[k]);
         pe_in[k] = $signed(geo1_ff.d2[k]) * $signed(geo1_ff.d2[k]);
         pb_in[k] = $signed(geo1_ff.d1[k]) * $signed(geo1_ff.d2[k]);
         pc_in[k] = $signed(geo1_ff.d1[k]) * $signed(geo1_ff.r[k]);
         pf_in[k] = $signed(geo1_ff.d2[k]) * $signed(geo1_ff.r[k]);
      end
      a_in = DOTW'(pa_ff[0]) + DOTW'(pa_ff[1]) + DOTW'(pa_ff[2]);
      e_in = DOTW'(pe_ff[0]) + DOTW'(pe_ff[1]) + DOTW'(pe_ff[2]);
      b_in = DOTW'(pb_ff[0]) + DOTW'(pb_ff[1]) + DOTW'(pb_ff[2]);
      c_in = DOTW'(pc_ff[0]) + DOTW'(pc_ff[1]) + DOTW'(pc_ff[2]);
      f_in = DOTW'(pf_ff[0]) + DOTW'(pf_ff[1]) + DOTW'(pf_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         geo1_ff <= geo1_in;
         geo2_ff <= geo1_ff;
         geo3_ff <= geo2_ff;
         for (int k = 0; k < 3; k++) begin
            pa_ff[k] <= pa_in[k];
            pe_ff[k] <= pe_in[k];
            pb_ff[k] <= pb_in[k];
            pc_ff[k] <= pc_in[k];
            pf_ff[k] <= pf_in[k];
         end
         a_ff <= a_in;
         e_ff <= e_in;
         b_ff <= b_in;
         c_ff <= c_in;
         f_ff <= f_in;
      end
   end

   assign a_o   = a_ff;
   assign e_o   = e_ff;
   assign b_o   = b_ff;
   assign c_o   = c_ff;
   assign f_o   = f_ff;
   assign geo_o = geo3_ff;

endmodule

/* hdl/ssd_dist.sv */
module ssd_dist (
   input  logic                          clock,
   input  logic                          en,
   input  ssd_pkg::side_type             side_i,
   input  ssd_pkg::div_res_type          tres_i,
   output logic [ssd_pkg::DIST_W-1:0]    dist_o,
   output logic [ssd_pkg::QW-1:0]        s_o,
   output logic [ssd_pkg::QW-1:0]        t_o
);
   import ssd_pkg::*;

   localparam int SH_W = SUM_W - 2 * PB;

   logic [QW-1:0]          sel_s_in, sel_t_in;
   logic [QW-1:0]          s_ff [1:DIST_LAT];
   logic [QW-1:0]          t_ff [1:DIST_LAT];
   geo_type                geo_ff;
   logic signed [CMPW-1:0] ds_in [0:2], dt_in [0:2], rs_in [0:2], comp_in [0:2];
   logic signed [CMPW-1:0] ds_ff [0:2], dt_ff [0:2], rs_ff [0:2], comp_ff [0:2];
   logic signed [PW-1:0]   sq [0:2];
   logic [SUM_W-1:0]       sum_in, sum_ff;
   logic [SH_W-1:0]        sh;
   logic [DIST_W-1:0]      dist_in, dist_ff;

   // Degenerate segments pin their own parameter to the start point; in the
   // general case the sign of the t numerator, and whether it exceeds its denominator, pick which s stands.
   always_comb begin
      if (side_i.pa && side_i.pe) begin
         sel_s_in = '0;
         sel_t_in = '0;
      end else if (side_i.pa) begin
         sel_s_in = '0;
         sel_t_in = tres_i.q;
      end else if (side_i.pe) begin
         sel_s_in = side_i.q_neg;
         sel_t_in = '0;
      end else begin
         sel_t_in = tres_i.q;
         if (tres_i.neg) begin
            sel_s_in = side_i.q_neg;
         end else if (tres_i.gt) begin
            sel_s_in = side_i.q_bc;
         end else begin
            sel_s_in = side_i.s0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ds_in[k]   = $signed(geo_ff.d1[k]) * $signed({1'b0, s_ff[1]});
         dt_in[k]   = $signed(geo_ff.d2[k]) * $signed({1'b0, t_ff[1]});
         rs_in[k]   = CMPW'($signed(geo_ff.r[k])) <<< PB;
         comp_in[k] = rs_ff[k] + ds_ff[k] - dt_ff[k];
      end
      sum_in = SUM_W'(sq[0][SQW-1:0]) + SUM_W'(sq[1][SQW-1:0]) + SUM_W'(sq[2][SQW-1:0])
             + ROUND;
      sh     = sum_ff[SUM_W-1:2*PB];
      if (|sh[SH_W-1:DIST_W]) begin
         dist_in = '1;
      end else begin
         dist_in = sh[DIST_W-1:0];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_sq
      ssd_mul u_sq (
         .clock (clock),
         .en    (en),
         .a_i   (MW'(comp_ff[k])),
         .b_i   (MW'(comp_ff[k])),
         .p_o   (sq[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[1] <= sel_s_in;
         t_ff[1] <= sel_t_in;
         for (int i = 2; i <= DIST_LAT; i++) begin
            s_ff[i] <= s_ff[i-1];
            t_ff[i] <= t_ff[i-1];
         end
         geo_ff <= side_i.geo;
         for (int k = 0; k < 3; k++) begin
            ds_ff[k]   <= ds_in[k];
            dt_ff[k]   <= dt_in[k];
            rs_ff[k]   <= rs_in[k];
            comp_ff[k] <= comp_in[k];
         end
         sum_ff  <= sum_in;
         dist_ff <= dist_in;
      end
   end

   assign dist_o = dist_ff;
   assign s_o    = s_ff[DIST_LAT];
   assign t_o    = t_ff[DIST_LAT];

endmodule

/* hdl/segment_segment_distance_top.sv */
// Closest approach of two 3-D segments.
// The req_ channel carries one word per segment pair: twelve signed Q11.12
// coordinates. The rsp_ channel returns one word for each: the squared
// distance of the closest points (Q24, rounded, saturated) and the clamped
// parameters s and t in Q1.16. csr_wen with csr_wdata sets the squared-length
// threshold at or below which a segment counts as a point; it resets to 17 and
// should only be changed while no word is in flight.
// The block is a fixed pipeline of 50 register stages: a new word may enter
// on every cycle while the output is not stalled. The length is set
// by two 17-stage restoring dividers in series (s, then t) and the split
// wide multipliers between them.
// Reset clears every valid bit, so the pipeline comes up empty.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready falls; words already inside are held, not
// lost, and the whole pipeline moves on again once the result is taken.
module segment_segment_distance_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // fields from bit 0: first_start_x/y/z, first_end_x/y/z,
   // second_start_x/y/z, second_end_x/y/z, 24 bits each
   input  logic [ssd_pkg::IN_W-1:0]      req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // fields from bit 0: distance_squared (52), param_first (17),
   // param_second (17), two zero bits
   output logic [ssd_pkg::OUT_W-1:0]     rsp_tdata,
   input  logic                          csr_wen,
   input  logic [ssd_pkg::THR_W-1:0]     csr_wdata
);
   import ssd_pkg::*;

   logic                    adv;
   logic [ST_OUT:1]         vld_ff;
   logic [THR_W-1:0]        thr_ff;
   dot_type                 a_d, e_d, b_d, c_d, f_d;
   geo_type                 geo_d;
   side_type                side_in, alt_in, s0_in;
   side_type                side_ff [ST_PRE:ST_T];
   logic [DEN_W-1:0]        a4_ff;
   logic signed [NUM_W-1:0] n1_ff, n2_ff;
   logic signed [PW-1:0]    p_ae, p_bb, p_bf, p_ce, p_bs;
   logic [DEN_W-1:0]        den_ff, ep_ff;
   logic signed [NUM_W-1:0] snum_ff, tn_ff;
   div_res_type             r_neg, r_bc, r_s, r_t;
   logic [QW-1:0]           s_sel;
   logic [DIST_W-1:0]       dist_out;
   logic [QW-1:0]           s_out, t_out;

   assign adv        = !vld_ff[ST_OUT] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = OUT_W'({t_out, s_out, dist_out});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_OUT-1:1], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   ssd_dot u_dot (
      .clock   (clock),
      .en      (adv),
      .coord_i (req_tdata),
      .a_o     (a_d),
      .e_o     (e_d),
      .b_o     (b_d),
      .c_o     (c_d),
      .f_o     (f_d),
      .geo_o   (geo_d)
   );

   always_comb begin
      side_in.b     = b_d;
      side_in.f     = f_d;
      side_in.e     = e_d;
      side_in.pa    = a_d[DOTW-2:0] <= (DOTW-1)'(thr_ff);
      side_in.pe    = e_d[DOTW-2:0] <= (DOTW-1)'(thr_ff);
      side_in.q_neg = '0;
      side_in.q_bc  = '0;
      side_in.s0    = '0;
      side_in.geo   = geo_d;
      s_sel         = side_ff[ST_S0].pa ? '0 : r_s.q;
      alt_in        = side_ff[ST_ALT];
      alt_in.q_neg  = r_neg.q;
      alt_in.q_bc   = r_bc.q;
      s0_in         = side_ff[ST_S0];
      s0_in.s0      = s_sel;
   end

   ssd_mul u_ae (.clock(clock), .en(adv), .a_i(a_d), .b_i(e_d), .p_o(p_ae));
   ssd_mul u_bb (.clock(clock), .en(adv), .a_i(b_d), .b_i(b_d), .p_o(p_bb));
   ssd_mul u_bf (.clock(clock), .en(adv), .a_i(b_d), .b_i(f_d), .p_o(p_bf));
   ssd_mul u_ce (.clock(clock), .en(adv), .a_i(c_d), .b_i(e_d), .p_o(p_ce));

   // A zero determinant means parallel segments: a zero numerator forces s to 0.
   always_ff @(posedge clock) begin
      if (adv) begin
         a4_ff   <= DEN_W'(a_d[DOTW-2:0]);
         n1_ff   <= -NUM_W'(c_d);
         n2_ff   <= NUM_W'(b_d) - NUM_W'(c_d);
         den_ff  <= DEN_W'(p_ae - p_bb);
         snum_ff <= (p_ae == p_bb) ? '0 : (p_bf - p_ce);
         tn_ff   <= p_bs + (NUM_W'(side_ff[ST_BS].f) <<< PB);
         ep_ff   <= DEN_W'(side_ff[ST_BS].e[DOTW-2:0]) << PB;
         side_ff[ST_PRE] <= side_in;
         for (int k = ST_PRE + 1; k <= ST_T; k++) begin
            if (k == ST_ALT + 1) begin
               side_ff[k] <= alt_in;
            end else if (k == ST_S0 + 1) begin
               side_ff[k] <= s0_in;
            end else begin
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   end

   ssd_div u_dneg (.clock(clock), .en(adv), .num_i(n1_ff), .den_i(a4_ff), .res_o(r_neg));
   ssd_div u_dbc  (.clock(clock), .en(adv), .num_i(n2_ff), .den_i(a4_ff), .res_o(r_bc));
   ssd_div u_ds   (.clock(clock), .en(adv), .num_i(snum_ff), .den_i(den_ff), .res_o(r_s));

   ssd_mul u_bs (
      .clock (clock),
      .en    (adv),
      .a_i   (side_ff[ST_S0].b),
      .b_i   (MW'($signed({1'b0, s_sel}))),
      .p_o   (p_bs)
   );

   ssd_div u_dt (.clock(clock), .en(adv), .num_i(tn_ff), .den_i(ep_ff), .res_o(r_t));

   ssd_dist u_dist (
      .clock  (clock),
      .en     (adv),
      .side_i (side_ff[ST_T]),
      .tres_i (r_t),
      .dist_o (dist_out),
      .s_o    (s_out),
      .t_o    (t_out)
   );

endmodule

/* test/segment_segment_distance_top_tb.sv */
module segment_segment_distance_top_tb;
   import ssd_pkg::*;

   localparam int PIPE_LAT = 50;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic [51:0] dist_sq;
      logic [16:0] s_param;
      logic [16:0] t_param;
   } closest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [THR_W-1:0] csr_wdata = '0;

   logic [IN_W-1:0] pending_pairs[$];
   closest_type expected_closest[$];
   logic [THR_W-1:0] point_threshold;
   int mismatch_count = 0;
   int stall_cycles = 0;
   bit calm = 1'b0;

   segment_segment_distance_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Truncating clamped quotient in Q1.16; den is positive.
   function automatic logic [16:0] clamped_ratio(logic signed [255:0] num,
                                                 logic signed [255:0] den);
      logic signed [255:0] q;
      if (num <= 0) return 17'd0;
      if (num >= den) return 17'h10000;
      q = (num <<< PB) / den;
      return q[16:0];
   endfunction

   function automatic closest_type closest_approach(logic [IN_W-1:0] pair,
                                                    logic [THR_W-1:0] thr);
      logic signed [255:0] p[12];
      logic signed [255:0] d1[3], d2[3], r[3];
      logic signed [255:0] a, e, b, c, f, den, tn, ep, comp, acc, one;
      logic signed [255:0] s, t;
      bit pa, pe;
      closest_type res;
      for (int k = 0; k < 12; k++) p[k] = coord_type'(pair[k*CW +: CW]);
      for (int k = 0; k < 3; k++) begin
         d1[k] = p[3+k] - p[k];
         d2[k] = p[9+k] - p[6+k];
         r[k] = p[k] - p[6+k];
      end
      a = 0; e = 0; b = 0; c = 0; f = 0;
      for (int k = 0; k < 3; k++) begin
         a += d1[k] * d1[k];
         e += d2[k] * d2[k];
         b += d1[k] * d2[k];
         c += d1[k] * r[k];
         f += d2[k] * r[k];
      end
      one = 256'sd65536;
      s = 0;
      t = 0;
      pa = a <= $signed({235'd0, thr});
      pe = e <= $signed({235'd0, thr});
      if (pa && pe) begin
      end else if (pa) begin
         t = clamped_ratio(f, e);
      end else if (pe) begin
         s = clamped_ratio(-c, a);
      end else begin
         den = a * e - b * b;
         if (den != 0) s = clamped_ratio(b * f - c * e, den);
         tn = b * s + f * one;
         ep = e * one;
         if (tn < 0) begin
            t = 0;
            s = clamped_ratio(-c, a);
         end else if (tn > ep) begin
            t = one;
            s = clamped_ratio(b - c, a);
         end else begin
            t = clamped_ratio(tn, ep);
         end
      end
      acc = 0;
      for (int k = 0; k < 3; k++) begin
         comp = r[k] * one + d1[k] * s - d2[k] * t;
         acc += comp * comp;
      end
      acc = (acc + (256'sd1 <<< 31)) >>> 32;
      res.dist_sq = (acc > 256'sh0F_FFFF_FFFF_FFFF) ? 52'hF_FFFF_FFFF_FFFF : acc[51:0];
      res.s_param = s[16:0];
      res.t_param = t[16:0];
      return res;
   endfunction

   function automatic coord_type random_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 8191) - 4096);
         2: return coord_type'($urandom_range(0, 1 << 18) - (1 << 17));
         default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      endcase
   endfunction

   function automatic logic [IN_W-1:0] pack_pair(coord_type c[12]);
      logic [IN_W-1:0] w;
      for (int k = 0; k < 12; k++) w[k*CW +: CW] = c[k];
      return w;
   endfunction

   // Builds a segment pair with random shape: zero-length, short or
   // parallel segments, or plain random coordinates.
   function automatic logic [IN_W-1:0] random_pair();
      coord_type c[12];
      int mode, shape;
      mode = $urandom_range(0, 5);
      if (mode > 3) mode = 2;
      for (int k = 0; k < 12; k++) c[k] = random_coord(mode);
      shape = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         case (shape)
            0: c[3+k] = coord_type'(c[k] + $urandom_range(0, 4) - 2);
            1: c[9+k] = coord_type'(c[6+k] + $urandom_range(0, 4) - 2);
            2: c[9+k] = c[6+k] + (c[3+k] - c[k]);
            3: c[9+k] = coord_type'(c[6+k] - 2 * (c[3+k] - c[k]));
            4: begin
               c[3+k] = c[k];
               c[9+k] = c[6+k];
            end
            default: ;
         endcase
      end
      return pack_pair(c);
   endfunction

   task automatic write_threshold(logic [THR_W-1:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      point_threshold = value;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic drain_pipeline();
      wait (pending_pairs.size() == 0 && !req_tvalid);
      wait (expected_closest.size() == 0);
      repeat (PIPE_LAT + 5) @(posedge clock);
   endtask

   // The word at the head of the queue is the one on the bus until it is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) void'(pending_pairs.pop_front());
         if (pending_pairs.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_pairs[0];
         end else if (!req_tvalid || req_tready) begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= calm || $urandom_range(0, 99) >= 13;
      end
   end

   // The predictor runs at acceptance so it uses the threshold then in force.
   always @(posedge clock) begin
      closest_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_closest.push_back(closest_approach(req_tdata, point_threshold));
         if (rsp_tvalid && rsp_tready) begin
            got.dist_sq = rsp_tdata[51:0];
            got.s_param = rsp_tdata[68:52];
            got.t_param = rsp_tdata[85:69];
            if (expected_closest.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected word: %h", rsp_tdata);
            end else begin
               want = expected_closest.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Mismatch: expected d=%0d s=%0d t=%0d, got d=%0d s=%0d t=%0d",
                              want.dist_sq, want.s_param, want.t_param,
                              got.dist_sq, got.s_param, got.t_param);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (pending_pairs.size() == 0 && expected_closest.size() == 0))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      coord_type c[12];
      logic [THR_W-1:0] thresholds[5];
      point_threshold = THR_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs: extremes, both points, one point, parallel, crossing.
      foreach (c[k]) c[k] = 24'h7FFFFF;
      pending_pairs.push_back(pack_pair(c));
      foreach (c[k]) c[k] = 24'h800000;
      pending_pairs.push_back(pack_pair(c));
      foreach (c[k]) c[k] = (k < 6) ? 24'h800000 : 24'h7FFFFF;
      pending_pairs.push_back(pack_pair(c));
      foreach (c[k]) c[k] = (k % 2) ? 24'h800000 : 24'h7FFFFF;
      pending_pairs.push_back(pack_pair(c));
      foreach (c[k]) c[k] = '0;
      c[6] = 24'h001000;
      pending_pairs.push_back(pack_pair(c));
      c[9] = 24'h003000; c[10] = 24'h002000;
      pending_pairs.push_back(pack_pair(c));
      foreach (c[k]) c[k] = '0;
      c[3] = 24'h001000; c[4] = 24'h002000; c[6] = 24'h000800; c[7] = 24'h005000;
      pending_pairs.push_back(pack_pair(c));
      foreach (c[k]) c[k] = '0;
      c[3] = 24'h004000; c[7] = 24'h001000; c[9] = 24'h004000; c[10] = 24'h001000;
      pending_pairs.push_back(pack_pair(c));
      c[6] = 24'h00A000; c[9] = 24'h00E000;
      pending_pairs.push_back(pack_pair(c));
      foreach (c[k]) c[k] = '0;
      c[3] = 24'h004000; c[6] = 24'h002000; c[7] = 24'hFFE000; c[8] = 24'h001000;
      c[10] = 24'h002000; c[11] = 24'h001000;
      pending_pairs.push_back(pack_pair(c));
      c[6] = 24'h00C000; c[9] = 24'h00C000;
      pending_pairs.push_back(pack_pair(c));
      c[6] = 24'hFF8000; c[9] = 24'hFF8000;
      pending_pairs.push_back(pack_pair(c));
      foreach (c[k]) c[k] = '0;
      c[3] = 24'h000002; c[9] = 24'h000004;
      pending_pairs.push_back(pack_pair(c));
      drain_pipeline();

      thresholds = '{21'd0, 21'h100000, 21'd1, 21'd4000, THR_RESET};
      for (int phase = 0; phase < 5; phase++) begin
         write_threshold(thresholds[phase]);
         for (int n = 0; n < 20; n++) begin
            foreach (c[k]) c[k] = coord_type'($urandom_range(0, 64) - 32);
            pending_pairs.push_back(pack_pair(c));
         end
         for (int n = 0; n < 190; n++) pending_pairs.push_back(random_pair());
         calm = (phase == 2);
         drain_pipeline();
         calm = 1'b0;
      end

      if (mismatch_count == 0 && expected_closest.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
